// ===== rtl/sfs_pkg.sv =====
package sfs_pkg;

  localparam int unsigned CMD_W       = 2;
  localparam int unsigned DELTA_W     = 24;
  localparam int unsigned ENTRY_IDX_W = 8;
  localparam int unsigned ENTRY_VAL_W = 16;
  localparam int unsigned FRAME_W     = 8;
  localparam int unsigned COORD_U_W   = 16;
  localparam int unsigned COORD_V_W   = 24;
  localparam int unsigned LEN_W       = 9;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned DUR_W       = 32;
  localparam int unsigned SUM_W       = DUR_W + FRAME_W;
  localparam int unsigned FRAMES_LIM  = 256;
  localparam int unsigned PC_W        = 5;

  localparam int unsigned MAX_FRAMES_DEF = 256;
  localparam int unsigned TIME_BITS_DEF  = 32;

  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WR_DUR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_WR_SEQ  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_LENGTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_LIST_LEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_LEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_U        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_V        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd7;

  localparam logic [LEN_W-1:0] RST_FRAME_COUNT   = 9'd1;
  localparam logic [CFG_W-1:0] RST_DEFAULT_TICKS = 16'd1;
  localparam logic [CFG_W-1:0] RST_TICK_LENGTH   = 16'd50000;

  typedef struct packed {
    logic [LEN_W-1:0] frame_count;
    logic [CFG_W-1:0] default_frame_ticks;
    logic [CFG_W-1:0] tick_length;
    logic [LEN_W-1:0] time_list_len;
    logic [LEN_W-1:0] sequence_len;
    logic [CFG_W-1:0] base_u;
    logic [CFG_W-1:0] base_v;
    logic [CFG_W-1:0] frame_height;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_EXEC,
    OP_RD_CUR,
    OP_RD_IDX,
    OP_MUL,
    OP_FIX,
    OP_SUM_CLR,
    OP_SUM_ADD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_ACC_REM,
    OP_STEP,
    OP_SHOW,
    OP_OUT
  } op_e;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_IN_VALID,
    C_NOT_ADV,
    C_ACC_LT_DUR,
    C_IDX_MORE,
    C_ACC_LT_SUM,
    C_DIV_MORE,
    C_OUT_FREE
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic            stay;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic not_adv;
    logic acc_lt_dur;
    logic idx_more;
    logic acc_lt_sum;
    logic div_more;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/sprite_frame_sequencer_unit.sv =====
// Sprite animation frame timer with a small microcoded sequencer. Each input transaction
// (advance, reset animation, write duration entry, write sequence entry) returns one result
// transaction with the frame counter, the frame shown after sequence mapping and the texture
// coordinate. One item is in flight at a time, and the next is taken while the previous result
// still waits in the output register. An advance that crosses a frame boundary also runs a
// pass over the duration table for the n frames in use, a restoring remainder at one bit a
// cycle when the accumulator holds at least a whole cycle of all frames (skipped otherwise),
// and a stepping loop over at most n - 1 frames with a final check; each table has a single
// read port. The tables need no clearing after reset; entries below a loaded length must be
// written before they are used.
module sprite_frame_sequencer_unit
  import sfs_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int unsigned TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [47:0]          s_axis_tdata_i,  // delta_time, entry_index, entry_value
  input  logic [CMD_W-1:0]     s_axis_tuser_i,  // cmd
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [55:0]          m_axis_tdata_o,  // frame_index, shown_frame, coord_u, coord_v
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cfg_t    cfg_q;
  ucode_t  ctrl;
  status_t status;

  logic [FRAME_W-1:0]   frame_index;
  logic [FRAME_W-1:0]   shown_frame;
  logic [COORD_U_W-1:0] coord_u;
  logic [COORD_V_W-1:0] coord_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_count         <= RST_FRAME_COUNT;
      cfg_q.default_frame_ticks <= RST_DEFAULT_TICKS;
      cfg_q.tick_length         <= RST_TICK_LENGTH;
      cfg_q.time_list_len       <= '0;
      cfg_q.sequence_len        <= '0;
      cfg_q.base_u              <= '0;
      cfg_q.base_v              <= '0;
      cfg_q.frame_height        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_COUNT:   cfg_q.frame_count         <= cfg_data_i[LEN_W-1:0];
        REG_DEFAULT_TICKS: cfg_q.default_frame_ticks <= cfg_data_i;
        REG_TICK_LENGTH:   cfg_q.tick_length         <= cfg_data_i;
        REG_TIME_LIST_LEN: cfg_q.time_list_len       <= cfg_data_i[LEN_W-1:0];
        REG_SEQUENCE_LEN:  cfg_q.sequence_len        <= cfg_data_i[LEN_W-1:0];
        REG_BASE_U:        cfg_q.base_u              <= cfg_data_i;
        REG_BASE_V:        cfg_q.base_v              <= cfg_data_i;
        REG_FRAME_HEIGHT:  cfg_q.frame_height        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sfs_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .status_i   (status),
    .in_ready_o (s_axis_tready_o),
    .ctrl_o     (ctrl)
  );

  sfs_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .TIME_BITS  (TIME_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cfg_i         (cfg_q),
    .cmd_i         (s_axis_tuser_i),
    .delta_i       (s_axis_tdata_i[23:0]),
    .entry_idx_i   (s_axis_tdata_i[31:24]),
    .entry_val_i   (s_axis_tdata_i[47:32]),
    .status_o      (status),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .frame_index_o (frame_index),
    .shown_frame_o (shown_frame),
    .coord_u_o     (coord_u),
    .coord_v_o     (coord_v)
  );

  assign m_axis_tdata_o = {coord_v, coord_u, shown_frame, frame_index};

endmodule

// ===== rtl/sfs_ram.sv =====
module sfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sfs_seq.sv =====
module sfs_seq
  import sfs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output ucode_t  ctrl_o
);

  localparam logic [PC_W-1:0] P_IDLE      = 5'd0;
  localparam logic [PC_W-1:0] P_EXEC      = 5'd1;
  localparam logic [PC_W-1:0] P_CUR_RD    = 5'd2;
  localparam logic [PC_W-1:0] P_CUR_MUL   = 5'd3;
  localparam logic [PC_W-1:0] P_CUR_CHK   = 5'd4;
  localparam logic [PC_W-1:0] P_SUM_CLR   = 5'd5;
  localparam logic [PC_W-1:0] P_SUM_RD    = 5'd6;
  localparam logic [PC_W-1:0] P_SUM_MUL   = 5'd7;
  localparam logic [PC_W-1:0] P_SUM_ADD   = 5'd8;
  localparam logic [PC_W-1:0] P_DIV_INIT  = 5'd9;
  localparam logic [PC_W-1:0] P_DIV_STEP  = 5'd10;
  localparam logic [PC_W-1:0] P_DIV_DONE  = 5'd11;
  localparam logic [PC_W-1:0] P_LOOP_RD   = 5'd12;
  localparam logic [PC_W-1:0] P_LOOP_MUL  = 5'd13;
  localparam logic [PC_W-1:0] P_LOOP_STEP = 5'd14;
  localparam logic [PC_W-1:0] P_LOOP_BACK = 5'd15;
  localparam logic [PC_W-1:0] P_SHOW_RD   = 5'd16;
  localparam logic [PC_W-1:0] P_SHOW_MUL  = 5'd17;
  localparam logic [PC_W-1:0] P_SHOW_OUT  = 5'd18;

  function automatic ucode_t rom(input logic [PC_W-1:0] addr);
    ucode_t w;
    unique case (addr)
      P_IDLE:      w = '{OP_LOAD,     C_IN_VALID,   1'b1, P_EXEC};
      P_EXEC:      w = '{OP_EXEC,     C_NOT_ADV,    1'b0, P_SHOW_RD};
      P_CUR_RD:    w = '{OP_RD_CUR,   C_NONE,       1'b0, P_IDLE};
      P_CUR_MUL:   w = '{OP_MUL,      C_NONE,       1'b0, P_IDLE};
      P_CUR_CHK:   w = '{OP_FIX,      C_ACC_LT_DUR, 1'b0, P_SHOW_RD};
      P_SUM_CLR:   w = '{OP_SUM_CLR,  C_NONE,       1'b0, P_IDLE};
      P_SUM_RD:    w = '{OP_RD_IDX,   C_NONE,       1'b0, P_IDLE};
      P_SUM_MUL:   w = '{OP_MUL,      C_NONE,       1'b0, P_IDLE};
      P_SUM_ADD:   w = '{OP_SUM_ADD,  C_IDX_MORE,   1'b0, P_SUM_RD};
      P_DIV_INIT:  w = '{OP_DIV_INIT, C_ACC_LT_SUM, 1'b0, P_LOOP_RD};
      P_DIV_STEP:  w = '{OP_DIV_STEP, C_DIV_MORE,   1'b0, P_DIV_STEP};
      P_DIV_DONE:  w = '{OP_ACC_REM,  C_NONE,       1'b0, P_IDLE};
      P_LOOP_RD:   w = '{OP_RD_CUR,   C_NONE,       1'b0, P_IDLE};
      P_LOOP_MUL:  w = '{OP_MUL,      C_NONE,       1'b0, P_IDLE};
      P_LOOP_STEP: w = '{OP_STEP,     C_ACC_LT_DUR, 1'b0, P_SHOW_RD};
      P_LOOP_BACK: w = '{OP_NOP,      C_ALWAYS,     1'b0, P_LOOP_RD};
      P_SHOW_RD:   w = '{OP_RD_CUR,   C_NONE,       1'b0, P_IDLE};
      P_SHOW_MUL:  w = '{OP_SHOW,     C_NONE,       1'b0, P_IDLE};
      P_SHOW_OUT:  w = '{OP_OUT,      C_OUT_FREE,   1'b1, P_IDLE};
      default:     w = '{OP_NOP,      C_ALWAYS,     1'b0, P_IDLE};
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] pc_q, pc_d;
  ucode_t          ctrl;
  logic            take;

  assign ctrl = rom(pc_q);

  always_comb begin
    unique case (ctrl.cond)
      C_ALWAYS:     take = 1'b1;
      C_IN_VALID:   take = in_valid_i;
      C_NOT_ADV:    take = status_i.not_adv;
      C_ACC_LT_DUR: take = status_i.acc_lt_dur;
      C_IDX_MORE:   take = status_i.idx_more;
      C_ACC_LT_SUM: take = status_i.acc_lt_sum;
      C_DIV_MORE:   take = status_i.div_more;
      C_OUT_FREE:   take = status_i.out_free;
      default:      take = 1'b0;
    endcase
    if (take) begin
      pc_d = ctrl.target;
    end else if (ctrl.stay) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= P_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign in_ready_o = (pc_q == P_IDLE);
  assign ctrl_o     = ctrl;

endmodule

// ===== rtl/sfs_datapath.sv =====
module sfs_datapath
  import sfs_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int unsigned TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ucode_t                 ctrl_i,
  input  cfg_t                   cfg_i,
  input  logic [CMD_W-1:0]       cmd_i,
  input  logic [DELTA_W-1:0]     delta_i,
  input  logic [ENTRY_IDX_W-1:0] entry_idx_i,
  input  logic [ENTRY_VAL_W-1:0] entry_val_i,
  output status_t                status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [FRAME_W-1:0]     frame_index_o,
  output logic [FRAME_W-1:0]     shown_frame_o,
  output logic [COORD_U_W-1:0]   coord_u_o,
  output logic [COORD_V_W-1:0]   coord_v_o
);

  localparam int unsigned TBL_DEPTH = (MAX_FRAMES < FRAMES_LIM) ? MAX_FRAMES : FRAMES_LIM;
  localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);
  localparam int unsigned CW        = (TIME_BITS > SUM_W) ? TIME_BITS : SUM_W;
  localparam int unsigned CNT_W     = $clog2(TIME_BITS);

  // latched item
  logic [CMD_W-1:0]       cmd_q;
  logic [DELTA_W-1:0]     delta_q;
  logic [ENTRY_IDX_W-1:0] eidx_q;
  logic [ENTRY_VAL_W-1:0] eval_q;

  logic [TIME_BITS-1:0] acc_q, acc_d;
  logic [FRAME_W-1:0]   cur_q, cur_d;
  logic [FRAME_W-1:0]   idx_q, idx_d;
  logic [DUR_W-1:0]     dur_q, dur_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [SUM_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 tl_hit_q, tl_hit_d;
  logic                 seq_hit_q, seq_hit_d;
  logic [FRAME_W-1:0]   shown_q, shown_d;
  logic [COORD_V_W-1:0] prod_q, prod_d;
  logic                 out_valid_q, out_valid_d;
  logic [FRAME_W-1:0]   out_frame_q;
  logic [FRAME_W-1:0]   out_shown_q;
  logic [COORD_U_W-1:0] out_u_q;
  logic [COORD_V_W-1:0] out_v_q;

  logic [LEN_W-1:0]       fc_lim, n_frames;
  logic [FRAME_W-1:0]     rd_addr;
  logic                   rd_in_tbl;
  logic [CFG_W-1:0]       ticks;
  logic [DUR_W-1:0]       tprod;
  logic [CW-1:0]          acc_ext, dur_ext, sum_ext, rem_ext, acc_sub;
  logic [CW:0]            acc_add;
  logic                   acc_sat;
  logic                   acc_lt_dur, acc_lt_sum;
  logic [SUM_W:0]         div_t, div_diff;
  logic                   div_ge;
  logic [LEN_W-1:0]       cur_inc;
  logic                   cur_wrap;
  logic                   out_free, out_load;
  logic                   dur_we, seq_we;
  logic [ENTRY_VAL_W-1:0] dur_rdata;
  logic [FRAME_W-1:0]     seq_rdata;
  logic [FRAME_W-1:0]     shown_sel;

  sfs_ram #(
    .WIDTH (ENTRY_VAL_W),
    .DEPTH (TBL_DEPTH)
  ) u_dur_ram (
    .clk_i   (clk_i),
    .we_i    (dur_we),
    .waddr_i (eidx_q[TBL_AW-1:0]),
    .wdata_i (eval_q),
    .raddr_i (rd_addr[TBL_AW-1:0]),
    .rdata_o (dur_rdata)
  );

  sfs_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (TBL_DEPTH)
  ) u_seq_ram (
    .clk_i   (clk_i),
    .we_i    (seq_we),
    .waddr_i (eidx_q[TBL_AW-1:0]),
    .wdata_i (eval_q[FRAME_W-1:0]),
    .raddr_i (rd_addr[TBL_AW-1:0]),
    .rdata_o (seq_rdata)
  );

  always_comb begin
    fc_lim   = (cfg_i.frame_count > LEN_W'(TBL_DEPTH)) ? LEN_W'(TBL_DEPTH) : cfg_i.frame_count;
    n_frames = (fc_lim == '0) ? LEN_W'(1) : fc_lim;

    rd_addr   = (ctrl_i.op == OP_RD_IDX) ? idx_q : cur_q;
    rd_in_tbl = (32'(rd_addr) < MAX_FRAMES);

    ticks = tl_hit_q ? dur_rdata : cfg_i.default_frame_ticks;
    tprod = {16'd0, ticks} * {16'd0, cfg_i.tick_length};

    acc_ext    = CW'(acc_q);
    dur_ext    = CW'(dur_q);
    sum_ext    = CW'(sum_q);
    rem_ext    = CW'(rem_q);
    acc_sub    = acc_ext - dur_ext;
    acc_add    = {1'b0, acc_ext} + (CW + 1)'(delta_q);
    acc_sat    = |acc_add[CW:TIME_BITS];
    acc_lt_dur = (acc_ext < dur_ext);
    acc_lt_sum = (acc_ext < sum_ext);

    div_t    = {rem_q, acc_q[TIME_BITS-1]};
    div_diff = div_t - {1'b0, sum_q};
    div_ge   = (div_t >= {1'b0, sum_q});

    cur_inc  = {1'b0, cur_q} + LEN_W'(1);
    cur_wrap = (cur_inc >= n_frames);

    shown_sel = seq_hit_q ? seq_rdata : cur_q;

    out_free = !out_valid_q || out_ready_i;
    out_load = (ctrl_i.op == OP_OUT) && out_free;

    dur_we = (ctrl_i.op == OP_EXEC) && (cmd_q == CMD_WR_DUR) && (32'(eidx_q) < MAX_FRAMES);
    seq_we = (ctrl_i.op == OP_EXEC) && (cmd_q == CMD_WR_SEQ) && (32'(eidx_q) < MAX_FRAMES);
  end

  always_comb begin
    acc_d     = acc_q;
    cur_d     = cur_q;
    idx_d     = idx_q;
    dur_d     = dur_q;
    sum_d     = sum_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    tl_hit_d  = tl_hit_q;
    seq_hit_d = seq_hit_q;
    shown_d   = shown_q;
    prod_d    = prod_q;
    unique case (ctrl_i.op) inside
      OP_EXEC: begin
        if (cmd_q == CMD_ADVANCE) begin
          acc_d = acc_sat ? '1 : acc_add[TIME_BITS-1:0];
        end else if (cmd_q == CMD_RESET) begin
          acc_d = '0;
          cur_d = '0;
        end
      end
      OP_RD_CUR, OP_RD_IDX: begin
        tl_hit_d  = rd_in_tbl && ({1'b0, rd_addr} < cfg_i.time_list_len);
        seq_hit_d = rd_in_tbl && ({1'b0, rd_addr} < cfg_i.sequence_len);
      end
      OP_MUL: begin
        dur_d = (tprod == '0) ? DUR_W'(1) : tprod;
      end
      OP_FIX: begin
        if (!acc_lt_dur && ({1'b0, cur_q} >= n_frames)) begin
          acc_d = acc_sub[TIME_BITS-1:0];
          cur_d = '0;
        end
      end
      OP_SUM_CLR: begin
        sum_d = '0;
        idx_d = '0;
      end
      OP_SUM_ADD: begin
        sum_d = sum_q + SUM_W'(dur_q);
        idx_d = idx_q + FRAME_W'(1);
      end
      OP_DIV_INIT: begin
        rem_d = '0;
        cnt_d = '0;
      end
      OP_DIV_STEP: begin
        rem_d = div_ge ? div_diff[SUM_W-1:0] : div_t[SUM_W-1:0];
        acc_d = {acc_q[TIME_BITS-2:0], 1'b0};
        cnt_d = cnt_q + CNT_W'(1);
      end
      OP_ACC_REM: begin
        acc_d = rem_ext[TIME_BITS-1:0];
      end
      OP_STEP: begin
        if (!acc_lt_dur) begin
          acc_d = acc_sub[TIME_BITS-1:0];
          cur_d = cur_wrap ? '0 : cur_inc[FRAME_W-1:0];
        end
      end
      OP_SHOW: begin
        shown_d = shown_sel;
        prod_d  = COORD_V_W'(shown_sel) * COORD_V_W'(cfg_i.frame_height);
      end
      default: ;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_LOAD) begin
      cmd_q   <= cmd_i;
      delta_q <= delta_i;
      eidx_q  <= entry_idx_i;
      eval_q  <= entry_val_i;
    end
    idx_q     <= idx_d;
    dur_q     <= dur_d;
    sum_q     <= sum_d;
    rem_q     <= rem_d;
    cnt_q     <= cnt_d;
    tl_hit_q  <= tl_hit_d;
    seq_hit_q <= seq_hit_d;
    shown_q   <= shown_d;
    prod_q    <= prod_d;
    if (out_load) begin
      out_frame_q <= cur_q;
      out_shown_q <= shown_q;
      out_u_q     <= cfg_i.base_u;
      out_v_q     <= COORD_V_W'(cfg_i.base_v) + prod_q;
    end
  end

  assign status_o.not_adv    = (cmd_q != CMD_ADVANCE);
  assign status_o.acc_lt_dur = acc_lt_dur;
  assign status_o.idx_more   = (({1'b0, idx_q} + LEN_W'(1)) < n_frames);
  assign status_o.acc_lt_sum = acc_lt_sum;
  assign status_o.div_more   = (cnt_q != CNT_W'(TIME_BITS - 1));
  assign status_o.out_free   = out_free;

  assign out_valid_o   = out_valid_q;
  assign frame_index_o = out_frame_q;
  assign shown_frame_o = out_shown_q;
  assign coord_u_o     = out_u_q;
  assign coord_v_o     = out_v_q;

endmodule

// ===== sim/tb_sprite_frame_sequencer_unit.sv =====
module tb_sprite_frame_sequencer_unit;
  import sfs_pkg::*;

  localparam int unsigned N_FR = MAX_FRAMES_DEF;
  localparam longint unsigned ACC_TOP = 64'hFFFF_FFFF;
  localparam int unsigned HOLD_LONG = 300;
  localparam int unsigned IN_W = DELTA_W + ENTRY_IDX_W + ENTRY_VAL_W;
  localparam int unsigned OUT_W = 2 * FRAME_W + COORD_U_W + COORD_V_W;

  typedef struct packed {
    logic [COORD_V_W-1:0] coord_v;
    logic [COORD_U_W-1:0] coord_u;
    logic [FRAME_W-1:0]   shown_frame;
    logic [FRAME_W-1:0]   frame_index;
  } frame_out_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_valid = 1'b0;
  logic [IN_W-1:0]      s_data = '0;
  logic [CMD_W-1:0]     s_cmd = CMD_ADVANCE;
  logic                 m_ready = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_FRAME_COUNT;
  logic [CFG_W-1:0]     cfg_data = '0;
  wire                  s_ready;
  wire                  m_valid;
  wire  [OUT_W-1:0]     m_data;

  sprite_frame_sequencer_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_cmd),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // register copies
  logic [LEN_W-1:0] fc_r       = RST_FRAME_COUNT;
  logic [CFG_W-1:0] ticks_def_r = RST_DEFAULT_TICKS;
  logic [CFG_W-1:0] tick_len_r = RST_TICK_LENGTH;
  logic [LEN_W-1:0] dur_len_r  = '0;
  logic [LEN_W-1:0] seq_len_r  = '0;
  logic [CFG_W-1:0] base_u_r   = '0;
  logic [CFG_W-1:0] base_v_r   = '0;
  logic [CFG_W-1:0] fheight_r  = '0;

  // animation state
  longint unsigned  acc_us = 0;
  int unsigned      cur_fr = 0;
  logic [CFG_W-1:0] dur_tab [N_FR];
  logic [FRAME_W-1:0] seq_tab [N_FR];
  bit               dur_done [N_FR];
  bit               seq_done [N_FR];

  frame_out_t expected_frames [$];
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned errors = 0;
  int unsigned n_adv = 0, n_rst = 0, n_wr = 0, n_checked = 0, n_cfg = 0;

  function automatic int unsigned clip(input int unsigned v, input int unsigned hi);
    return (v > hi) ? hi : v;
  endfunction

  function automatic int unsigned frames_used();
    int unsigned n;
    n = clip(fc_r, N_FR);
    return (n == 0) ? 1 : n;
  endfunction

  function automatic longint unsigned frame_time(input int unsigned f);
    longint unsigned ticks;
    longint unsigned d;
    ticks = ticks_def_r;
    if (f < clip(dur_len_r, N_FR)) ticks = dur_tab[f];
    d = ticks * tick_len_r;
    return (d == 0) ? 1 : d;
  endfunction

  function automatic void step_frames();
    int unsigned n;
    int unsigned i;
    longint unsigned d;
    longint unsigned cyc;
    n = frames_used();
    cyc = 0;
    if (cur_fr >= n) begin
      d = frame_time(cur_fr);
      if (acc_us < d) return;
      acc_us -= d;
      cur_fr = 0;
    end
    for (i = 0; i < n; i++) cyc += frame_time(i);
    acc_us = acc_us % cyc;
    forever begin
      d = frame_time(cur_fr);
      if (acc_us < d) break;
      acc_us -= d;
      cur_fr = (cur_fr + 1 >= n) ? 0 : cur_fr + 1;
    end
  endfunction

  function automatic frame_out_t predict_frame(input logic [CMD_W-1:0] cmd,
                                               input logic [DELTA_W-1:0] delta,
                                               input logic [ENTRY_IDX_W-1:0] idx,
                                               input logic [ENTRY_VAL_W-1:0] val);
    frame_out_t r;
    int unsigned shown;
    case (cmd)
      CMD_ADVANCE: begin
        acc_us = (delta > ACC_TOP - acc_us) ? ACC_TOP : acc_us + delta;
        step_frames();
      end
      CMD_RESET: begin
        cur_fr = 0;
        acc_us = 0;
      end
      CMD_WR_DUR: begin
        dur_tab[idx] = val;
        dur_done[idx] = 1'b1;
      end
      default: begin
        seq_tab[idx] = val[FRAME_W-1:0];
        seq_done[idx] = 1'b1;
      end
    endcase
    shown = cur_fr;
    if (cur_fr < clip(seq_len_r, N_FR)) shown = seq_tab[cur_fr];
    r.frame_index = FRAME_W'(cur_fr);
    r.shown_frame = FRAME_W'(shown);
    r.coord_u     = base_u_r;
    r.coord_v     = COORD_V_W'(base_v_r + shown * fheight_r);
    return r;
  endfunction

  function automatic int unsigned written_prefix(input bit seq);
    int unsigned i;
    i = 0;
    while (i < N_FR && (seq ? seq_done[i] : dur_done[i])) i++;
    return i;
  endfunction

  task automatic offer_command(input logic [CMD_W-1:0] cmd, input logic [DELTA_W-1:0] delta,
                               input logic [ENTRY_IDX_W-1:0] idx,
                               input logic [ENTRY_VAL_W-1:0] val);
    while (!calm && $urandom_range(99) < 19) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_cmd   <= cmd;
    s_data  <= {val, idx, delta};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    expected_frames.push_back(predict_frame(cmd, delta, idx, val));
    case (cmd)
      CMD_ADVANCE: n_adv++;
      CMD_RESET:   n_rst++;
      default:     n_wr++;
    endcase
  endtask

  task automatic wait_results();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_frames.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_FRAME_COUNT:   fc_r = val[LEN_W-1:0];
      REG_DEFAULT_TICKS: ticks_def_r = val;
      REG_TICK_LENGTH:   tick_len_r = val;
      REG_TIME_LIST_LEN: dur_len_r = val[LEN_W-1:0];
      REG_SEQUENCE_LEN:  seq_len_r = val[LEN_W-1:0];
      REG_BASE_U:        base_u_r = val;
      REG_BASE_V:        base_v_r = val;
      default:           fheight_r = val;
    endcase
    n_cfg++;
  endtask

  task automatic load_config(input int unsigned fc, input int unsigned ticks,
                             input int unsigned tlen, input int unsigned dlen,
                             input int unsigned slen, input int unsigned bu,
                             input int unsigned bv, input int unsigned fh);
    write_reg(REG_FRAME_COUNT, CFG_W'(fc));
    write_reg(REG_DEFAULT_TICKS, CFG_W'(ticks));
    write_reg(REG_TICK_LENGTH, CFG_W'(tlen));
    write_reg(REG_TIME_LIST_LEN, CFG_W'(dlen));
    write_reg(REG_SEQUENCE_LEN, CFG_W'(slen));
    write_reg(REG_BASE_U, CFG_W'(bu));
    write_reg(REG_BASE_V, CFG_W'(bv));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(fh));
  endtask

  task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // result side: check against the oldest expectation, random or long stalls
  always @(posedge clk_i) begin : result_side
    frame_out_t got;
    frame_out_t want;
    if (rst_ni && m_valid && m_ready) begin
      got = frame_out_t'(m_data);
      if (expected_frames.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none actual %h", $time, got);
      end else begin
        want = expected_frames.pop_front();
        n_checked++;
        flag_field("frame_index", want.frame_index, got.frame_index);
        flag_field("shown_frame", want.shown_frame, got.shown_frame);
        flag_field("coord_u", want.coord_u, got.coord_u);
        flag_field("coord_v", want.coord_v, got.coord_v);
      end
    end
    if (hold_req) begin
      hold_left = HOLD_LONG;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= calm || ($urandom_range(99) >= 19);
    end
  end

  task automatic test_directed();
    offer_command(CMD_ADVANCE, '0, '0, '0);
    offer_command(CMD_ADVANCE, 24'd50000, '1, '1);
    offer_command(CMD_ADVANCE, '1, '0, '0);
    offer_command(CMD_RESET, '1, '1, '1);
    offer_command(CMD_WR_DUR, '0, 8'd0, 16'd0);
    offer_command(CMD_WR_DUR, '0, 8'd1, 16'hFFFF);
    offer_command(CMD_WR_DUR, '0, 8'd2, 16'd2);
    offer_command(CMD_WR_DUR, '0, 8'd3, 16'd1);
    offer_command(CMD_WR_SEQ, '0, 8'd0, 16'h00FF);
    offer_command(CMD_WR_SEQ, '0, 8'd1, 16'hFF00);
    offer_command(CMD_WR_SEQ, '0, 8'd2, 16'h0003);
    offer_command(CMD_WR_SEQ, '0, 8'd3, 16'h5A80);
    wait_results();
    // zero-tick entry at frame zero
    load_config(4, 3, 1000, 4, 4, 16'hFFFF, 16'h1234, 16'hFFFF);
    offer_command(CMD_ADVANCE, '0, '0, '0);
    offer_command(CMD_ADVANCE, 24'd1, '0, '0);
    offer_command(CMD_ADVANCE, '1, '0, '0);
    offer_command(CMD_ADVANCE, '1, '0, '0);
    wait_results();
    write_reg(REG_TICK_LENGTH, '0);
    offer_command(CMD_ADVANCE, '1, '0, '0);
    wait_results();
    // shrink the frame count below the current frame
    load_config(8, 1, 1000, 0, 0, 0, 0, 300);
    offer_command(CMD_RESET, '0, '0, '0);
    offer_command(CMD_ADVANCE, 24'd5500, '0, '0);
    wait_results();
    write_reg(REG_FRAME_COUNT, CFG_W'(3));
    offer_command(CMD_ADVANCE, 24'd600, '0, '0);
    wait_results();
    write_reg(REG_FRAME_COUNT, CFG_W'(0));
    offer_command(CMD_ADVANCE, 24'd2500, '0, '0);
    wait_results();
  endtask

  task automatic test_saturation();
    calm = 1'b1;
    load_config(1, 16'hFFFF, 16'hFFFF, 0, 0, $urandom, $urandom, $urandom);
    offer_command(CMD_RESET, '0, '0, '0);
    repeat (255) offer_command(CMD_ADVANCE, '1, '0, '0);
    offer_command(CMD_ADVANCE, DELTA_W'($urandom_range(1000, 100000)), '0, '0);
    repeat (5) offer_command(CMD_ADVANCE, '1, '0, '0);
    wait_results();
    calm = 1'b0;
  endtask

  task automatic test_full_tables();
    int unsigned i;
    for (i = 0; i < N_FR; i++) begin
      offer_command(CMD_WR_DUR, DELTA_W'($urandom), ENTRY_IDX_W'(i),
                    ($urandom_range(31) == 0) ? 16'hFFFF : ENTRY_VAL_W'($urandom_range(3)));
    end
    for (i = 0; i < N_FR; i++) begin
      offer_command(CMD_WR_SEQ, DELTA_W'($urandom), ENTRY_IDX_W'(i), ENTRY_VAL_W'($urandom));
    end
    wait_results();
    load_config(300, $urandom, $urandom_range(1, 3), 300, 300, $urandom, $urandom, $urandom);
    repeat (30) offer_command(CMD_ADVANCE, DELTA_W'($urandom), '0, '0);
    wait_results();
    write_reg(REG_FRAME_COUNT, CFG_W'(256));
    write_reg(REG_TIME_LIST_LEN, CFG_W'(256));
    write_reg(REG_SEQUENCE_LEN, CFG_W'(256));
    repeat (10) offer_command(CMD_ADVANCE, DELTA_W'($urandom), '0, '0);
    wait_results();
  endtask

  task automatic test_backpressure();
    load_config(5, 2, 100, written_prefix(1'b0) > 5 ? 5 : written_prefix(1'b0), 0,
                $urandom, $urandom, $urandom);
    hold_req = 1'b1;
    repeat (24) begin
      if ($urandom_range(3) == 0)
        offer_command(CMD_WR_SEQ, DELTA_W'($urandom), ENTRY_IDX_W'($urandom),
                      ENTRY_VAL_W'($urandom));
      else
        offer_command(CMD_ADVANCE, DELTA_W'($urandom_range(0, 600)), '0, '0);
    end
    wait_results();
  endtask

  task automatic random_item();
    int unsigned k;
    int unsigned span;
    int unsigned pick;
    longint unsigned d;
    k = $urandom_range(99);
    if (k < 70) begin
      d = frame_time(cur_fr);
      span = (d > 64'd5592405) ? 32'hFF_FFFF : 32'(3 * d);
      offer_command(CMD_ADVANCE, DELTA_W'($urandom_range(0, span)),
                    ENTRY_IDX_W'($urandom), ENTRY_VAL_W'($urandom));
    end else if (k < 85) begin
      offer_command(CMD_ADVANCE, DELTA_W'($urandom), ENTRY_IDX_W'($urandom),
                    ENTRY_VAL_W'($urandom));
    end else if (k < 90) begin
      offer_command(CMD_RESET, DELTA_W'($urandom), ENTRY_IDX_W'($urandom),
                    ENTRY_VAL_W'($urandom));
    end else if (k < 95) begin
      pick = $urandom_range(1) ? clip(written_prefix(1'b0), N_FR - 1) : $urandom_range(255);
      offer_command(CMD_WR_DUR, DELTA_W'($urandom), ENTRY_IDX_W'(pick),
                    $urandom_range(7) == 0 ? ENTRY_VAL_W'($urandom)
                                           : ENTRY_VAL_W'($urandom_range(8)));
    end else begin
      pick = $urandom_range(1) ? clip(written_prefix(1'b1), N_FR - 1) : $urandom_range(255);
      offer_command(CMD_WR_SEQ, DELTA_W'($urandom), ENTRY_IDX_W'(pick),
                    ENTRY_VAL_W'($urandom));
    end
  endtask

  task automatic test_random_phases();
    int unsigned fc, ticks, tlen;
    repeat (12) begin
      wait_results();
      fc    = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 256 : 1) : $urandom_range(1, 12);
      ticks = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(8);
      case ($urandom_range(9))
        0:       tlen = 0;
        1:       tlen = 65535;
        2:       tlen = $urandom_range(65535);
        default: tlen = $urandom_range(1, 200);
      endcase
      load_config(fc, ticks, tlen, $urandom_range(0, written_prefix(1'b0)),
                  $urandom_range(0, written_prefix(1'b1)), $urandom, $urandom, $urandom);
      repeat (40) random_item();
    end
    wait_results();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_saturation();
    test_backpressure();
    test_full_tables();
    test_random_phases();
    wait_results();
    repeat (2000) @(posedge clk_i);
    $display("Sent %0d transactions: %0d advances, %0d animation resets, %0d table writes",
             n_adv + n_rst + n_wr, n_adv, n_rst, n_wr);
    $display("Checked %0d results over %0d register writes, incl. saturation and long stalls",
             n_checked, n_cfg);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sprite_frame_sequencer_unit.f =====
rtl/sfs_pkg.sv
rtl/sfs_ram.sv
rtl/sfs_seq.sv
rtl/sfs_datapath.sv
rtl/sprite_frame_sequencer_unit.sv
sim/tb_sprite_frame_sequencer_unit.sv
